// File: sv/sfd_pkg.sv
// Shared types and constants for the sample frame deframer.
package sfd_pkg;

    localparam int MAX_SAMPLES_DEF = 2048;
    localparam int HEADER_BYTES    = 16;
    localparam int NOTICE_MAX      = 64;

    localparam int KIND_W   = 3;
    localparam int SEQ_W    = 16;
    localparam int TYPE_W   = 8;
    localparam int COUNT_W  = 12;
    localparam int SAMPLE_W = 16;
    localparam int INDEX_W  = 11;
    localparam int LIMIT_W  = 16;
    localparam int NCNT_W   = $clog2(NOTICE_MAX + 1);

    localparam logic [31:0] MAGIC_WORD = 32'hAABBCCDD;
    localparam logic [7:0]  SIG_BYTE   = 8'h5A;
    localparam logic [31:0] TAG_WORD   = 32'h20260206;

    localparam logic [LIMIT_W-1:0] GOOD_LIMIT_RST = 16'd4095;
    localparam logic [COUNT_W-1:0] MAX_COUNT_RST  = 12'd2048;

    localparam logic CFG_GOOD_LIMIT = 1'b0;
    localparam logic CFG_MAX_COUNT  = 1'b1;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACCEPT  = 3'd0,
        KIND_SIG_TAG = 3'd1,
        KIND_COUNT   = 3'd2,
        KIND_LENGTH  = 3'd3,
        KIND_OVER    = 3'd4,
        KIND_READ    = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [SEQ_W-1:0]     seq;
        logic [TYPE_W-1:0]    frame_type;
        logic [COUNT_W-1:0]   sample_count;
        logic [SAMPLE_W-1:0]  max_sample;
        logic [COUNT_W-1:0]   bad_count;
        logic [INDEX_W-1:0]   first_bad;
        logic [SAMPLE_W-1:0]  read_sample;
        logic                 last;
    } res_t;

endpackage

// File: sv/sfd_core.sv
// Byte ring buffer, frame scan sequencer and sample store.
module sfd_core #(
    parameter int MAX_SAMPLES = sfd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_op,
    input  logic [7:0]                    in_byte,
    input  logic [sfd_pkg::INDEX_W-1:0]   in_idx,
    input  logic [sfd_pkg::LIMIT_W-1:0]   good_limit,
    input  logic [sfd_pkg::COUNT_W-1:0]   max_count,
    output logic                          res_valid,
    input  logic                          res_ready,
    output sfd_pkg::res_t                 res
);
    import sfd_pkg::*;

    localparam int STORE_DEPTH = HEADER_BYTES + 2 * MAX_SAMPLES;
    localparam int PTR_W       = $clog2(STORE_DEPTH + 1);
    localparam int RING        = 2 ** PTR_W;
    localparam int SIDX_W      = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_CHECK, ST_SRCH, ST_HCHK, ST_HDR, ST_EVAL,
        ST_SAMP, ST_SEVAL, ST_COPY, ST_NOTE, ST_FIN
    } state_t;

    state_t                 state_reg;
    logic                   phase_reg;
    logic [PTR_W-1:0]       head_reg;
    logic [PTR_W-1:0]       fill_reg;
    logic [PTR_W-1:0]       off_reg;
    logic [23:0]            win_reg;
    logic [95:0]            hdr_reg;
    logic [7:0]             lo_reg;
    logic [COUNT_W-1:0]     idx_reg;
    logic [SAMPLE_W-1:0]    maxv_reg;
    logic [COUNT_W-1:0]     bad_reg;
    logic [INDEX_W-1:0]     first_reg;
    logic [COUNT_W-1:0]     stored_reg;
    logic [INDEX_W-1:0]     rd_idx_reg;
    logic [NCNT_W-1:0]      ncnt_reg;
    logic [PTR_W-1:0]       drop_reg;
    res_t                   note_reg;
    res_t                   pend_reg;
    logic                   pend_valid_reg;

    logic [7:0]             bmem [RING];
    logic [SAMPLE_W-1:0]    smem [MAX_SAMPLES];
    logic [7:0]             brd;
    logic [SAMPLE_W-1:0]    srd;

    logic [PTR_W-1:0]       raddr;
    logic                   bwe;
    logic                   swe;
    logic [31:0]            cand;
    logic [SAMPLE_W-1:0]    sval;
    logic [SEQ_W-1:0]       h_seq;
    logic [TYPE_W-1:0]      h_type;
    logic [7:0]             h_sig;
    logic [15:0]            h_plen;
    logic [15:0]            h_cnt;
    logic [31:0]            h_tag;
    logic [COUNT_W-1:0]     limit;
    logic [16:0]            flen;
    logic                   last_smp;
    logic                   note_go;
    logic                   note_full;
    res_t                   rd_res;

    assign raddr  = head_reg + off_reg;
    assign cand   = {brd, win_reg};
    assign sval   = {brd, lo_reg};
    assign h_seq  = hdr_reg[15:0];
    assign h_type = hdr_reg[23:16];
    assign h_sig  = hdr_reg[31:24];
    assign h_plen = hdr_reg[47:32];
    assign h_cnt  = hdr_reg[63:48];
    assign h_tag  = hdr_reg[95:64];
    assign limit  = (max_count < COUNT_W'(MAX_SAMPLES)) ? max_count : COUNT_W'(MAX_SAMPLES);
    assign flen   = 17'(HEADER_BYTES) + {1'b0, h_plen};
    assign last_smp = (idx_reg + COUNT_W'(1)) == h_cnt[COUNT_W-1:0];

    assign in_ready = (state_reg == ST_IDLE);
    assign bwe = in_valid && in_ready && (in_op == OP_PUSH) && (fill_reg < PTR_W'(STORE_DEPTH));
    assign swe = (state_reg == ST_COPY) && phase_reg && off_reg[0];

    // notices beyond the cap are discarded but the scan continues
    assign note_full = (ncnt_reg == NCNT_W'(NOTICE_MAX));
    assign note_go   = note_full || !pend_valid_reg || res_ready;

    always_comb
    begin
        rd_res = '0;
        rd_res.kind = KIND_READ;
        rd_res.read_sample = ({1'b0, rd_idx_reg} < stored_reg) ? srd : '0;
        rd_res.last = 1'b1;
    end

    always_comb
    begin
        res_valid = 1'b0;
        res = pend_reg;
        unique case (state_reg)
            ST_RD:
            begin
                res_valid = phase_reg;
                res = rd_res;
            end
            ST_NOTE:
            begin
                res_valid = pend_valid_reg && !note_full;
            end
            ST_FIN:
            begin
                res_valid = pend_valid_reg;
                res.last = 1'b1;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (bwe)
        begin
            bmem[head_reg + fill_reg] <= in_byte;
        end
        brd <= bmem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (swe)
        begin
            smem[idx_reg[SIDX_W-1:0]] <= sval;
        end
        srd <= smem[rd_idx_reg[SIDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= 1'b0;
            head_reg       <= '0;
            fill_reg       <= '0;
            off_reg        <= '0;
            stored_reg     <= '0;
            ncnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        ncnt_reg <= '0;
                        if (in_op == OP_READ)
                        begin
                            rd_idx_reg <= in_idx;
                            phase_reg  <= 1'b0;
                            state_reg  <= ST_RD;
                        end
                        else
                        begin
                            if (bwe)
                            begin
                                fill_reg <= fill_reg + PTR_W'(1);
                            end
                            state_reg <= ST_CHECK;
                        end
                    end
                end
                ST_RD:
                begin
                    if (!phase_reg)
                    begin
                        phase_reg <= 1'b1;
                    end
                    else if (res_ready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_CHECK:
                begin
                    off_reg   <= '0;
                    phase_reg <= 1'b0;
                    state_reg <= (fill_reg < PTR_W'(HEADER_BYTES)) ? ST_FIN : ST_SRCH;
                end
                ST_SRCH:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        win_reg <= cand[31:8];
                        if (off_reg >= PTR_W'(3) && cand == MAGIC_WORD)
                        begin
                            head_reg  <= head_reg + (off_reg - PTR_W'(3));
                            fill_reg  <= fill_reg - (off_reg - PTR_W'(3));
                            state_reg <= ST_HCHK;
                        end
                        else if (off_reg + PTR_W'(1) == fill_reg)
                        begin
                            // no magic anywhere: keep the tail that may start one
                            head_reg  <= head_reg + (fill_reg - PTR_W'(3));
                            fill_reg  <= PTR_W'(3);
                            state_reg <= ST_FIN;
                        end
                        else
                        begin
                            off_reg <= off_reg + PTR_W'(1);
                        end
                    end
                end
                ST_HCHK:
                begin
                    off_reg   <= PTR_W'(4);
                    phase_reg <= 1'b0;
                    state_reg <= (fill_reg < PTR_W'(HEADER_BYTES)) ? ST_FIN : ST_HDR;
                end
                ST_HDR:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        hdr_reg <= {brd, hdr_reg[95:8]};
                        off_reg <= off_reg + PTR_W'(1);
                        if (off_reg == PTR_W'(HEADER_BYTES - 1))
                        begin
                            state_reg <= ST_EVAL;
                        end
                    end
                end
                ST_EVAL:
                begin
                    note_reg.seq         <= h_seq;
                    note_reg.frame_type  <= h_type;
                    note_reg.max_sample  <= '0;
                    note_reg.bad_count   <= '0;
                    note_reg.first_bad   <= '0;
                    note_reg.read_sample <= '0;
                    note_reg.last        <= 1'b0;
                    drop_reg             <= PTR_W'(4);
                    off_reg              <= PTR_W'(HEADER_BYTES);
                    phase_reg            <= 1'b0;
                    idx_reg              <= '0;
                    maxv_reg             <= '0;
                    bad_reg              <= '0;
                    first_reg            <= '0;
                    priority if (h_sig != SIG_BYTE || h_tag != TAG_WORD)
                    begin
                        note_reg.kind         <= KIND_SIG_TAG;
                        note_reg.sample_count <= '0;
                        state_reg             <= ST_NOTE;
                    end
                    else if (h_cnt == 16'd0 || h_cnt > {4'd0, limit})
                    begin
                        note_reg.kind         <= KIND_COUNT;
                        note_reg.sample_count <= '0;
                        state_reg             <= ST_NOTE;
                    end
                    else if ({1'b0, h_plen} != {h_cnt, 1'b0})
                    begin
                        note_reg.kind         <= KIND_LENGTH;
                        note_reg.sample_count <= h_cnt[COUNT_W-1:0];
                        state_reg             <= ST_NOTE;
                    end
                    else if ({{(17-PTR_W){1'b0}}, fill_reg} < flen)
                    begin
                        note_reg.kind         <= KIND_ACCEPT;
                        note_reg.sample_count <= '0;
                        state_reg             <= ST_FIN;
                    end
                    else
                    begin
                        note_reg.kind         <= KIND_ACCEPT;
                        note_reg.sample_count <= '0;
                        state_reg             <= ST_SAMP;
                    end
                end
                ST_SAMP:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        off_reg <= off_reg + PTR_W'(1);
                        if (!off_reg[0])
                        begin
                            lo_reg <= brd;
                        end
                        else
                        begin
                            if (sval > maxv_reg)
                            begin
                                maxv_reg <= sval;
                            end
                            if (sval > good_limit)
                            begin
                                if (bad_reg == '0)
                                begin
                                    first_reg <= idx_reg[INDEX_W-1:0];
                                end
                                bad_reg <= bad_reg + COUNT_W'(1);
                            end
                            idx_reg <= idx_reg + COUNT_W'(1);
                            if (last_smp)
                            begin
                                state_reg <= ST_SEVAL;
                            end
                        end
                    end
                end
                ST_SEVAL:
                begin
                    note_reg.sample_count <= h_cnt[COUNT_W-1:0];
                    note_reg.max_sample   <= maxv_reg;
                    off_reg               <= PTR_W'(HEADER_BYTES);
                    phase_reg             <= 1'b0;
                    idx_reg               <= '0;
                    if (bad_reg != '0)
                    begin
                        note_reg.kind      <= KIND_OVER;
                        note_reg.bad_count <= bad_reg;
                        note_reg.first_bad <= first_reg;
                        state_reg          <= ST_NOTE;
                    end
                    else
                    begin
                        note_reg.kind <= KIND_ACCEPT;
                        drop_reg      <= flen[PTR_W-1:0];
                        state_reg     <= ST_COPY;
                    end
                end
                ST_COPY:
                begin
                    phase_reg <= !phase_reg;
                    if (phase_reg)
                    begin
                        off_reg <= off_reg + PTR_W'(1);
                        if (!off_reg[0])
                        begin
                            lo_reg <= brd;
                        end
                        else
                        begin
                            idx_reg <= idx_reg + COUNT_W'(1);
                            if (last_smp)
                            begin
                                stored_reg <= h_cnt[COUNT_W-1:0];
                                state_reg  <= ST_NOTE;
                            end
                        end
                    end
                end
                ST_NOTE:
                begin
                    // last flag is unknown until the scan ends, so one notice waits here
                    if (note_go)
                    begin
                        if (!note_full)
                        begin
                            pend_reg       <= note_reg;
                            pend_valid_reg <= 1'b1;
                            ncnt_reg       <= ncnt_reg + NCNT_W'(1);
                        end
                        head_reg  <= head_reg + drop_reg;
                        fill_reg  <= fill_reg - drop_reg;
                        state_reg <= ST_CHECK;
                    end
                end
                ST_FIN:
                begin
                    if (!pend_valid_reg || res_ready)
                    begin
                        pend_valid_reg <= 1'b0;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= PTR_W'(STORE_DEPTH))
        else $error("byte ring overfilled");

    a_notice_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ncnt_reg <= NCNT_W'(NOTICE_MAX))
        else $error("notice count beyond cap");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending notice left behind");

    a_stored_bound: assert property (@(posedge clk) disable iff (!rst_n)
        stored_reg <= COUNT_W'(MAX_SAMPLES))
        else $error("stored count beyond sample store");

endmodule

// File: sv/sample_frame_deframer_top.sv
// Sample frame deframer: stream ports, config registers and output register.
// Each push runs a scan over the held bytes: a magic search and header check after
// each byte, and when a whole frame is present a check pass over its payload and,
// if no sample is over the limit, a copy pass into the sample store. Every rejection
// drops 4 bytes and restarts the scan. The byte memory has a registered read, so
// the scan spends an address step and a data step on each byte. Input is held off
// while a scan runs; up to 64 notices per push leave through a one-deep output
// register, the final one flagged with tlast.
module sample_frame_deframer_top #(
    parameter int MAX_SAMPLES = sfd_pkg::MAX_SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [23:0]                   s_tdata,   // data_byte, read_index, zero pad
    input  logic                          s_tuser,   // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // seq, frame_type, sample_count, max_sample, bad_count, first_bad, read_sample, pad
    output logic [95:0]                   m_tdata,
    output logic [sfd_pkg::KIND_W-1:0]    m_tuser,   // kind
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [15:0]                   cfg_data
);
    import sfd_pkg::*;

    logic [LIMIT_W-1:0]  good_limit_reg;
    logic [COUNT_W-1:0]  max_count_reg;
    logic                out_valid_reg;
    res_t                out_reg;
    logic                res_valid;
    logic                res_ready;
    res_t                res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            good_limit_reg <= GOOD_LIMIT_RST;
            max_count_reg  <= MAX_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GOOD_LIMIT: good_limit_reg <= cfg_data;
                CFG_MAX_COUNT:  max_count_reg  <= cfg_data[COUNT_W-1:0];
                default:        good_limit_reg <= good_limit_reg;
            endcase
        end
    end

    sfd_core #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_op      (s_tuser),
        .in_byte    (s_tdata[7:0]),
        .in_idx     (s_tdata[18:8]),
        .good_limit (good_limit_reg),
        .max_count  (max_count_reg),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {5'd0, out_reg.read_sample, out_reg.first_bad, out_reg.bad_count,
                       out_reg.max_sample, out_reg.sample_count, out_reg.frame_type,
                       out_reg.seq};

endmodule

// File: test/tb.sv
// Testbench for sample_frame_deframer_top: byte streams checked against a frame predictor.
module tb;
    import sfd_pkg::*;

    localparam int STORE_BYTES = HEADER_BYTES + 2 * MAX_SAMPLES_DEF;
    localparam int SETTLE_CYC  = 400;

    localparam int FAULT_NONE  = 0;
    localparam int FAULT_SIG   = 1;
    localparam int FAULT_TAG   = 2;
    localparam int FAULT_COUNT = 3;
    localparam int FAULT_LEN   = 4;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    logic [KIND_W-1:0] m_tuser;
    logic        m_tlast;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;

    sample_frame_deframer_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // predictor state
    logic [7:0]    held_bytes[$];
    logic [15:0]   sample_mem[MAX_SAMPLES_DEF];
    int unsigned   sample_cnt;
    logic [15:0]   good_limit;
    logic [11:0]   max_count;
    res_t          step_notices[$];
    res_t          pending_notices[$];
    int            notice_cnt;

    logic [7:0]    frame_buf[$];
    int            errors;
    int            checked;
    int            items_sent;
    int            snd_idle_pct;
    int            rcv_stall_pct;
    int            hold_cycles;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #40000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int unsigned held16(int unsigned at);
        return {held_bytes[at + 1], held_bytes[at]};
    endfunction

    function automatic int unsigned held32(int unsigned at);
        return (held16(at + 2) << 16) | held16(at);
    endfunction

    function automatic void drop_held(int unsigned n);
        if (n >= held_bytes.size())
            held_bytes.delete();
        else
            repeat (n) void'(held_bytes.pop_front());
    endfunction

    function automatic void add_notice(kind_t k, int unsigned sq, int unsigned ft,
                                       int unsigned cnt, int unsigned mx,
                                       int unsigned bc, int unsigned fb,
                                       int unsigned rs);
        res_t r;
        if (notice_cnt >= NOTICE_MAX)
            return;
        r.kind         = k;
        r.seq          = sq[15:0];
        r.frame_type   = ft[7:0];
        r.sample_count = cnt[11:0];
        r.max_sample   = mx[15:0];
        r.bad_count    = bc[11:0];
        r.first_bad    = fb[10:0];
        r.read_sample  = rs[15:0];
        r.last         = 1'b0;
        notice_cnt++;
        step_notices = {step_notices, r};
    endfunction

    function automatic void scan_held();
        int unsigned lim, pos, sq, ft, plen, cnt, flen, mx, bc, fb, v;
        bit found;
        lim = (max_count < MAX_SAMPLES_DEF) ? max_count : MAX_SAMPLES_DEF;
        while (1)
        begin
            if (held_bytes.size() < HEADER_BYTES)
                return;
            found = 0;
            for (pos = 0; pos + 4 <= held_bytes.size(); pos++)
            begin
                if (held32(pos) == MAGIC_WORD)
                begin
                    found = 1;
                    break;
                end
            end
            if (!found)
            begin
                if (held_bytes.size() > 3)
                    drop_held(held_bytes.size() - 3);
                return;
            end
            drop_held(pos);
            if (held_bytes.size() < HEADER_BYTES)
                return;
            sq   = held16(4);
            ft   = held_bytes[6];
            plen = held16(8);
            cnt  = held16(10);
            if (held_bytes[7] != SIG_BYTE || held32(12) != TAG_WORD)
            begin
                add_notice(KIND_SIG_TAG, sq, ft, 0, 0, 0, 0, 0);
                drop_held(4);
                continue;
            end
            if (cnt == 0 || cnt > lim)
            begin
                add_notice(KIND_COUNT, sq, ft, 0, 0, 0, 0, 0);
                drop_held(4);
                continue;
            end
            if (plen != cnt * 2)
            begin
                add_notice(KIND_LENGTH, sq, ft, cnt, 0, 0, 0, 0);
                drop_held(4);
                continue;
            end
            flen = HEADER_BYTES + plen;
            if (held_bytes.size() < flen)
                return;
            mx = 0;
            bc = 0;
            fb = 0;
            for (int unsigned i = 0; i < cnt; i++)
            begin
                v = held16(HEADER_BYTES + 2 * i);
                if (v > mx)
                    mx = v;
                if (v > good_limit)
                begin
                    if (bc == 0)
                        fb = i;
                    bc++;
                end
            end
            if (bc != 0)
            begin
                add_notice(KIND_OVER, sq, ft, cnt, mx, bc, fb, 0);
                drop_held(4);
                continue;
            end
            for (int unsigned i = 0; i < cnt; i++)
                sample_mem[i] = 16'(held16(HEADER_BYTES + 2 * i));
            sample_cnt = cnt;
            add_notice(KIND_ACCEPT, sq, ft, cnt, mx, 0, 0, 0);
            drop_held(flen);
        end
    endfunction

    // expected notices for one accepted transaction
    function automatic void predict_item(logic op, logic [7:0] b, logic [10:0] idx);
        notice_cnt = 0;
        step_notices.delete();
        if (op == OP_READ)
            add_notice(KIND_READ, 0, 0, 0, 0, 0, 0, (idx < sample_cnt) ? sample_mem[idx] : 0);
        else
        begin
            if (held_bytes.size() < STORE_BYTES)
                held_bytes = {held_bytes, b};
            scan_held();
        end
        if (step_notices.size() > 0)
            step_notices[step_notices.size() - 1].last = 1'b1;
        foreach (step_notices[i])
            pending_notices = {pending_notices, step_notices[i]};
    endfunction

    // output side: check and random stall
    initial
    begin
        res_t got, want;
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.kind         = kind_t'(m_tuser);
                got.seq          = m_tdata[15:0];
                got.frame_type   = m_tdata[23:16];
                got.sample_count = m_tdata[35:24];
                got.max_sample   = m_tdata[51:36];
                got.bad_count    = m_tdata[63:52];
                got.first_bad    = m_tdata[74:64];
                got.read_sample  = m_tdata[90:75];
                got.last         = m_tlast;
                checked++;
                if (pending_notices.size() == 0)
                begin
                    errors++;
                    $display("%0t unexpected transaction: kind=%0d seq=%h", $time,
                             got.kind, got.seq);
                end
                else
                begin
                    want = pending_notices.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        $display("%0t exp k=%0d seq=%h ft=%h cnt=%0d max=%h bad=%0d fb=%0d rs=%h l=%b",
                                 $time, want.kind, want.seq, want.frame_type, want.sample_count,
                                 want.max_sample, want.bad_count, want.first_bad,
                                 want.read_sample, want.last);
                        $display("%0t got k=%0d seq=%h ft=%h cnt=%0d max=%h bad=%0d fb=%0d rs=%h l=%b",
                                 $time, got.kind, got.seq, got.frame_type, got.sample_count,
                                 got.max_sample, got.bad_count, got.first_bad,
                                 got.read_sample, got.last);
                    end
                end
            end
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // called at a rising edge; leaves tvalid high after the transaction
    task automatic send_item(logic op, logic [7:0] b, logic [10:0] idx);
        int gap;
        gap = 0;
        while ($urandom_range(99) < snd_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, idx, b};
        do
            @(posedge clk);
        while (!s_tready);
        predict_item(op, b, idx);
        items_sent++;
    endtask

    task automatic send_buf();
        foreach (frame_buf[i])
            send_item(OP_PUSH, frame_buf[i], 11'($urandom_range(2047)));
        frame_buf.delete();
    endtask

    task automatic read_sample(logic [10:0] idx);
        send_item(OP_READ, 8'($urandom_range(255)), idx);
    endtask

    task automatic put16(int unsigned v);
        frame_buf = {frame_buf, v[7:0]};
        frame_buf = {frame_buf, v[15:8]};
    endtask

    task automatic put_header(int unsigned sq, int unsigned ft, int unsigned plen,
                              int unsigned cnt, logic [7:0] sig, logic [31:0] tag);
        put16(MAGIC_WORD[15:0]);
        put16(MAGIC_WORD[31:16]);
        put16(sq);
        frame_buf = {frame_buf, ft[7:0]};
        frame_buf = {frame_buf, sig};
        put16(plen);
        put16(cnt);
        put16(tag[15:0]);
        put16(tag[31:16]);
    endtask

    // one frame; each sample goes above the limit with chance n_over/cnt, where the limit allows it
    task automatic send_frame(int unsigned cnt, int fault, int n_over);
        int unsigned sq, ft, lim, v;
        logic [7:0]  sig;
        logic [31:0] tag;
        sq  = $urandom_range(65535);
        ft  = $urandom_range(255);
        sig = SIG_BYTE;
        tag = TAG_WORD;
        lim = (max_count < MAX_SAMPLES_DEF) ? max_count : MAX_SAMPLES_DEF;
        case (fault)
            FAULT_SIG:   sig = SIG_BYTE ^ (8'd1 << $urandom_range(7));
            FAULT_TAG:   tag = TAG_WORD ^ (32'd1 << $urandom_range(31));
            FAULT_COUNT: cnt = ($urandom_range(1) == 0) ? 0 : $urandom_range(65535, lim + 1);
            default: ;
        endcase
        put_header(sq, ft, (fault == FAULT_LEN) ? cnt * 2 + $urandom_range(3, 1) * 2 - 1
                                                 : cnt * 2,
                   cnt, sig, tag);
        if (fault == FAULT_NONE)
        begin
            for (int i = 0; i < cnt; i++)
            begin
                if (n_over > 0 && good_limit != 16'hFFFF && $urandom_range(cnt - 1) < n_over)
                    v = $urandom_range(65535, good_limit + 1);
                else
                    v = $urandom_range(good_limit);
                put16(v);
            end
        end
        send_buf();
    endtask

    // idle the input, let every notice drain and the scan finish
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_notices.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == CFG_GOOD_LIMIT)
            good_limit = value;
        else
            max_count = value[11:0];
    endtask

    task automatic test_reads_and_faults();
        read_sample(11'd0);
        read_sample(11'd2047);
        send_frame(1, FAULT_NONE, 0);
        read_sample(11'd0);
        read_sample(11'd1);
        send_frame(2, FAULT_SIG, 0);
        send_frame(2, FAULT_TAG, 0);
        send_frame(2, FAULT_COUNT, 0);
        send_frame(3, FAULT_LEN, 0);
        send_frame(3, FAULT_NONE, 2);
        // bytes with no magic in them
        for (int i = 0; i < 8; i++)
            send_item(OP_PUSH, (i % 2) ? 8'hFF : 8'h00, 11'd0);
        settle();
    endtask

    task automatic test_limit_extremes();
        write_reg(CFG_GOOD_LIMIT, 16'd0);
        write_reg(CFG_MAX_COUNT, 16'd1);
        send_frame(1, FAULT_NONE, 0);
        send_frame(1, FAULT_NONE, 1);
        send_frame(2, FAULT_NONE, 0);    // count above max_count
        settle();
        write_reg(CFG_GOOD_LIMIT, 16'hFFFF);
        write_reg(CFG_MAX_COUNT, 16'd2048);
        send_frame(4, FAULT_NONE, 0);
        read_sample(11'd3);
        settle();
    endtask

    // random mix until about n_items transactions have gone in
    task automatic test_random(int n_items);
        int r;
        int start;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            r = $urandom_range(99);
            if (r < 45)
                send_frame(($urandom_range(9) == 0) ? $urandom_range(12, 1)
                                                    : $urandom_range(3, 1), FAULT_NONE, 0);
            else if (r < 55)
                send_frame($urandom_range(3, 1), FAULT_NONE, $urandom_range(2, 1));
            else if (r < 65)
                send_frame($urandom_range(3, 1), $urandom_range(FAULT_LEN, FAULT_SIG), 0);
            else if (r < 82)
            begin
                repeat ($urandom_range(4, 1))
                    send_item(OP_PUSH, 8'($urandom_range(255)), 11'($urandom_range(2047)));
            end
            else if (sample_cnt > 0 && $urandom_range(3) != 0)
                read_sample(11'($urandom_range(sample_cnt - 1)));
            else
                read_sample(11'($urandom_range(2047)));
        end
    endtask

    task automatic test_output_stall();
        hold_cycles = 600;
        for (int i = 0; i < 6; i++)
            read_sample(11'($urandom_range(2047)));
        send_frame(2, FAULT_NONE, 0);
        settle();
    endtask

    initial
    begin
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_PUSH;
        cfg_we        = 1'b0;
        cfg_index     = CFG_GOOD_LIMIT;
        cfg_data      = '0;
        rst_n         = 1'b0;
        errors        = 0;
        checked       = 0;
        items_sent    = 0;
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_cycles   = 0;
        sample_cnt    = 0;
        good_limit    = GOOD_LIMIT_RST;
        max_count     = MAX_COUNT_RST;
        foreach (sample_mem[i])
            sample_mem[i] = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_reads_and_faults();
        test_limit_extremes();
        write_reg(CFG_GOOD_LIMIT, 16'd4095);
        write_reg(CFG_MAX_COUNT, 16'd8);
        test_random(20);
        settle();
        write_reg(CFG_MAX_COUNT, 16'd2048);
        snd_idle_pct = 72;
        test_random(20);
        settle();
        write_reg(CFG_GOOD_LIMIT, 16'($urandom_range(65535, 1000)));
        snd_idle_pct  = 0;
        rcv_stall_pct = 72;
        test_random(20);
        snd_idle_pct  = 34;
        rcv_stall_pct = 34;
        test_random(20);
        settle();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        test_output_stall();

        $display("Sent %0d transactions, checked %0d notices: header faults, limits,", items_sent,
                 checked);
        $display("reads, random traffic under idle and stall phases, a long output hold");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: files.f
sv/sfd_pkg.sv
sv/sfd_core.sv
sv/sample_frame_deframer_top.sv
test/tb.sv
